/* rtl/core/magic_length_frame_deframer_unit_defines.svh */
// Assertion macros for the magic/length frame deframer.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef MAGIC_LENGTH_FRAME_DEFRAMER_UNIT_DEFINES_SVH
`define MAGIC_LENGTH_FRAME_DEFRAMER_UNIT_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define MLFD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define MLFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/mlfd_pkg.sv */
// Types and fixed constants for the magic/length frame deframer.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package mlfd_pkg;

    // Configuration port
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [1:0] {
        REG_MAGIC_FIRST      = 2'd0,
        REG_MAGIC_SECOND     = 2'd1,
        REG_VERSION_EXPECTED = 2'd2
    } t_reg_idx;

    localparam logic [7:0] VERSION_RESET = 8'd1;

    // Header byte positions that are checked
    typedef logic [2:0] t_hdr_idx;
    localparam t_hdr_idx MAGIC0_POS  = 3'd0;
    localparam t_hdr_idx MAGIC1_POS  = 3'd1;
    localparam t_hdr_idx VERSION_POS = 3'd2;
    localparam t_hdr_idx LEN_LO_POS  = 3'd3;
    localparam t_hdr_idx LEN_HI_POS  = 3'd4;

    // Declared frame length: header + 16-bit length + CRC
    localparam int FLEN_W = 17;

    typedef enum logic [1:0] {
        EV_FRAME       = 2'd0,
        EV_BAD_VERSION = 2'd1,
        EV_OVERSIZE    = 2'd2
    } t_event_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_HD_RD,
        S_HD_EV,
        S_ERR,
        S_EM_RD,
        S_EM_WR
    } t_state;

endpackage

/* rtl/core/mlfd_if.sv */
// Valid/ready channel interfaces for the deframer: received bytes in,
// frame bytes and error events out. Standalone, no package needed.
`timescale 1ns / 1ps

interface mlfd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mlfd_ev_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_kind;
    logic [7:0] frame_byte;
    logic       frame_last;
    logic [6:0] frame_length;

    modport source (output valid, output event_kind, output frame_byte,
                    output frame_last, output frame_length, input ready);
    modport sink   (input valid, input event_kind, input frame_byte,
                    input frame_last, input frame_length, output ready);
endinterface

/* rtl/core/mlfd_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
// Read data holds until the next read. No dependencies.
`timescale 1ns / 1ps

module mlfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/core/magic_length_frame_deframer_unit.sv */
// Magic-word, length-prefixed frame deframer. Received bytes are appended to a
// circular byte buffer in one synchronous RAM. Once HEADER_BYTES are held, the
// header is read back one byte at a time (a RAM read, then a check): a bad magic
// byte drops one byte and rescans, a bad version or a declared length (header +
// little-endian length + CRC) above MAX_FRAME drops the header and sends one
// error event. A validated header is remembered, so a byte that does not finish
// the frame costs only an accept and a length check. A finished frame is sent
// byte by byte through the RAM read port, a read then a write per byte, and
// waits out any stall on the result channel. Bytes are taken only while the
// sequencer is idle; a result held in the output register does not block input.
// Writing any register discards the cached header check. The buffer needs no
// clearing after reset.
`timescale 1ns / 1ps
`include "magic_length_frame_deframer_unit_defines.svh"

module magic_length_frame_deframer_unit
    import mlfd_pkg::*;
#(
    parameter int MAX_FRAME    = 64,
    parameter int HEADER_BYTES = 5,
    parameter int CRC_BYTES    = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mlfd_rx_if.sink               i_rx,
    mlfd_ev_if.source             o_evt,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int PTR_W = $clog2(MAX_FRAME);
    localparam int CNT_W = $clog2(MAX_FRAME + 1);

    // Circular index: base + off, both below or at MAX_FRAME
    function automatic logic [PTR_W-1:0] f_wrap(input logic [CNT_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (CNT_W + 1)'(MAX_FRAME)) begin
            sum = sum - (CNT_W + 1)'(MAX_FRAME);
        end
        return sum[PTR_W-1:0];
    endfunction

    // Configuration
    logic [7:0] r_magic_first;
    logic [7:0] r_magic_second;
    logic [7:0] r_version_expected;
    logic       cfg_wr;
    t_reg_idx   cfg_idx;

    // Sequencer state
    t_state         r_state, n_state;
    logic [PTR_W-1:0] r_head, n_head;
    logic [CNT_W-1:0] r_count, n_count;
    logic           r_hdr_ok, n_hdr_ok;
    logic [CNT_W-1:0] r_flen, n_flen;
    logic [CNT_W-1:0] r_idx, n_idx;
    t_hdr_idx       r_k, n_k;
    logic [7:0]     r_len_lo, n_len_lo;
    t_event_kind    r_err_kind, n_err_kind;

    // Output register
    logic           r_out_valid, n_out_valid;
    t_event_kind    r_ev_kind, n_ev_kind;
    logic [7:0]     r_ev_byte, n_ev_byte;
    logic           r_ev_last, n_ev_last;
    logic [6:0]     r_ev_len, n_ev_len;

    // RAM access
    logic             ram_we;
    logic [PTR_W-1:0] ram_wr_addr;
    logic             ram_re;
    logic [PTR_W-1:0] ram_rd_addr;
    logic [7:0]       ram_rd_data;

    logic             rx_xfer;
    logic             slot_free;
    logic             emit_last;
    logic [FLEN_W-1:0] flen_calc;
    logic             hdr_short;

    assign cfg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb begin
        case (cfg_idx)
            REG_MAGIC_FIRST:      prdata = CFG_DATA_W'(r_magic_first);
            REG_MAGIC_SECOND:     prdata = CFG_DATA_W'(r_magic_second);
            REG_VERSION_EXPECTED: prdata = CFG_DATA_W'(r_version_expected);
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic_first      <= '0;
            r_magic_second     <= '0;
            r_version_expected <= VERSION_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_MAGIC_FIRST:      r_magic_first      <= pwdata[7:0];
                REG_MAGIC_SECOND:     r_magic_second     <= pwdata[7:0];
                REG_VERSION_EXPECTED: r_version_expected <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    mlfd_ram #(
        .WIDTH (8),
        .DEPTH (MAX_FRAME)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (i_rx.rx_byte),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign i_rx.ready = (r_state == S_IDLE);
    assign rx_xfer    = i_rx.valid && i_rx.ready;
    assign slot_free  = !r_out_valid || o_evt.ready;
    assign emit_last  = ({1'b0, r_idx} + 1'b1) == {1'b0, r_flen};
    assign flen_calc  = FLEN_W'(HEADER_BYTES + CRC_BYTES) + FLEN_W'({ram_rd_data, r_len_lo});
    assign hdr_short  = 32'(r_count) < HEADER_BYTES;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (rx_xfer) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (hdr_short) begin
                    n_state = S_IDLE;
                end else if (r_hdr_ok) begin
                    n_state = (r_count < r_flen) ? S_IDLE : S_EM_RD;
                end else begin
                    n_state = S_HD_RD;
                end
            end
            S_HD_RD: n_state = S_HD_EV;
            S_HD_EV: begin
                case (r_k)
                    MAGIC0_POS: n_state = (ram_rd_data != r_magic_first) ? S_SCAN : S_HD_RD;
                    MAGIC1_POS: n_state = (ram_rd_data != r_magic_second) ? S_SCAN : S_HD_RD;
                    VERSION_POS: begin
                        n_state = (ram_rd_data != r_version_expected) ? S_ERR : S_HD_RD;
                    end
                    LEN_LO_POS: n_state = S_HD_RD;
                    default: begin
                        n_state = (flen_calc > FLEN_W'(MAX_FRAME)) ? S_ERR : S_SCAN;
                    end
                endcase
            end
            S_ERR: begin
                if (slot_free) n_state = S_SCAN;
            end
            S_EM_RD: n_state = S_EM_WR;
            S_EM_WR: begin
                if (slot_free) n_state = emit_last ? S_SCAN : S_EM_RD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        n_head      = r_head;
        n_count     = r_count;
        n_hdr_ok    = r_hdr_ok;
        n_flen      = r_flen;
        n_idx       = r_idx;
        n_k         = r_k;
        n_len_lo    = r_len_lo;
        n_err_kind  = r_err_kind;
        n_out_valid = r_out_valid && !o_evt.ready;
        n_ev_kind   = r_ev_kind;
        n_ev_byte   = r_ev_byte;
        n_ev_last   = r_ev_last;
        n_ev_len    = r_ev_len;
        ram_we      = 1'b0;
        ram_wr_addr = f_wrap(CNT_W'(r_head), r_count);
        ram_re      = 1'b0;
        ram_rd_addr = f_wrap(CNT_W'(r_head), CNT_W'(r_k));

        case (r_state)
            S_IDLE: begin
                // a byte arriving into a full buffer is discarded
                if (rx_xfer && (r_count < CNT_W'(MAX_FRAME))) begin
                    ram_we  = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            S_SCAN: begin
                n_k   = MAGIC0_POS;
                n_idx = '0;
            end
            S_HD_RD: begin
                ram_re = 1'b1;
            end
            S_HD_EV: begin
                n_k = r_k + 1'b1;
                case (r_k)
                    MAGIC0_POS, MAGIC1_POS: begin
                        if ((r_k == MAGIC0_POS && ram_rd_data != r_magic_first) ||
                            (r_k == MAGIC1_POS && ram_rd_data != r_magic_second)) begin
                            // drop one byte and rescan
                            n_head  = f_wrap(CNT_W'(r_head), CNT_W'(1));
                            n_count = r_count - 1'b1;
                        end
                    end
                    VERSION_POS: begin
                        n_err_kind = EV_BAD_VERSION;
                    end
                    LEN_LO_POS: begin
                        n_len_lo = ram_rd_data;
                    end
                    default: begin
                        n_err_kind = EV_OVERSIZE;
                        if (flen_calc <= FLEN_W'(MAX_FRAME)) begin
                            n_flen   = flen_calc[CNT_W-1:0];
                            n_hdr_ok = 1'b1;
                        end
                    end
                endcase
            end
            S_ERR: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_ev_kind   = r_err_kind;
                    n_ev_byte   = '0;
                    n_ev_last   = 1'b1;
                    n_ev_len    = '0;
                    n_head      = f_wrap(CNT_W'(r_head), CNT_W'(HEADER_BYTES));
                    n_count     = r_count - CNT_W'(HEADER_BYTES);
                end
            end
            S_EM_RD: begin
                ram_re      = 1'b1;
                ram_rd_addr = f_wrap(CNT_W'(r_head), r_idx);
            end
            S_EM_WR: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_ev_kind   = EV_FRAME;
                    n_ev_byte   = ram_rd_data;
                    n_ev_last   = emit_last;
                    n_ev_len    = 7'(r_flen);
                    n_idx       = r_idx + 1'b1;
                    if (emit_last) begin
                        // frame sent: release it from the buffer
                        n_head   = f_wrap(CNT_W'(r_head), r_flen);
                        n_count  = r_count - r_flen;
                        n_hdr_ok = 1'b0;
                    end
                end
            end
            default: ;
        endcase

        // a register write may invalidate the held header
        if (cfg_wr) begin
            n_hdr_ok = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_hdr_ok    <= 1'b0;
            r_idx       <= '0;
            r_k         <= MAGIC0_POS;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_hdr_ok    <= n_hdr_ok;
            r_idx       <= n_idx;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_flen     <= n_flen;
        r_len_lo   <= n_len_lo;
        r_err_kind <= n_err_kind;
        r_ev_kind  <= n_ev_kind;
        r_ev_byte  <= n_ev_byte;
        r_ev_last  <= n_ev_last;
        r_ev_len   <= n_ev_len;
    end

    assign o_evt.valid        = r_out_valid;
    assign o_evt.event_kind   = r_ev_kind;
    assign o_evt.frame_byte   = r_ev_byte;
    assign o_evt.frame_last   = r_ev_last;
    assign o_evt.frame_length = r_ev_len;

    `MLFD_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_W'(MAX_FRAME), "byte count overflow")
    `MLFD_ASSERT_NOW(a_flen_range, r_hdr_ok, (32'(r_flen) >= HEADER_BYTES + CRC_BYTES) && (32'(r_flen) <= MAX_FRAME), "cached frame length out of range")
    `MLFD_ASSERT_NOW(a_idle_waits, (r_state == S_IDLE) && r_hdr_ok, r_count < r_flen, "idle with a complete frame held")
    `MLFD_ASSERT_NEXT(a_append, rx_xfer && (r_count < CNT_W'(MAX_FRAME)), r_count == $past(r_count) + 1'b1, "accepted byte not counted")

endmodule

/* tb/sv/magic_length_frame_deframer_unit_tb.sv */
// Self-checking testbench for magic_length_frame_deframer_unit: random byte streams,
// frame prediction in a scoreboard class, APB register writes between phases.
// Depends on mlfd_pkg and the channel interfaces in mlfd_if.sv.
`timescale 1ns / 1ps

module magic_length_frame_deframer_unit_tb;
    import mlfd_pkg::*;

    localparam int MAX_FRAME     = 64;
    localparam int HEADER_BYTES  = 5;
    localparam int CRC_BYTES     = 2;
    localparam int MAX_PAYLOAD   = MAX_FRAME - HEADER_BYTES - CRC_BYTES;
    localparam int SETTLE_CYCLES = 700;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int PHASE_BYTES   = 8;

    typedef struct packed {
        t_event_kind kind;
        logic [7:0]  data;
        logic        last;
        logic [6:0]  flen;
    } frame_evt_t;

    class frame_scoreboard;
        frame_evt_t  expected_q[$];
        logic [7:0]  held_bytes[$];
        logic [7:0]  magic_a;
        logic [7:0]  magic_b;
        logic [7:0]  version_req;
        int unsigned errors;

        function new();
            magic_a     = 8'h00;
            magic_b     = 8'h00;
            version_req = VERSION_RESET;
            errors      = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [7:0] v);
            case (idx)
                REG_MAGIC_FIRST:      magic_a = v;
                REG_MAGIC_SECOND:     magic_b = v;
                REG_VERSION_EXPECTED: version_req = v;
                default: ;
            endcase
        endfunction

        function void drop_front(int unsigned k);
            repeat (k) void'(held_bytes.pop_front());
        endfunction

        function void add_evt(t_event_kind kind, logic [7:0] data, logic last,
                              logic [6:0] flen);
            frame_evt_t e;
            e.kind = kind;
            e.data = data;
            e.last = last;
            e.flen = flen;
            expected_q.push_back(e);
        endfunction

        // Append one received byte (unless the buffer is full) and rescan the buffer from its start.
        function void note_byte(logic [7:0] b);
            int unsigned flen;
            int          n;
            int          i;
            n = 0;
            if (held_bytes.size() < MAX_FRAME) held_bytes.push_back(b);
            while (held_bytes.size() >= HEADER_BYTES && n < MAX_FRAME) begin
                if (held_bytes[0] != magic_a || held_bytes[1] != magic_b) begin
                    drop_front(1);
                    continue;
                end
                if (held_bytes[2] != version_req) begin
                    drop_front(HEADER_BYTES);
                    add_evt(EV_BAD_VERSION, 8'h00, 1'b1, 7'd0);
                    n++;
                    continue;
                end
                flen = HEADER_BYTES + CRC_BYTES + {held_bytes[4], held_bytes[3]};
                if (flen > MAX_FRAME) begin
                    drop_front(HEADER_BYTES);
                    add_evt(EV_OVERSIZE, 8'h00, 1'b1, 7'd0);
                    n++;
                    continue;
                end
                if (held_bytes.size() < flen) break;
                for (i = 0; i < int'(flen) && n < MAX_FRAME; i++) begin
                    add_evt(EV_FRAME, held_bytes[i], (i + 1 == int'(flen)), 7'(flen));
                    n++;
                end
                drop_front(flen);
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 50) $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task check(frame_evt_t got);
            frame_evt_t want;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result kind=%0d byte=%02h last=%0b len=%0d",
                                 got.kind, got.data, got.last, got.flen));
                return;
            end
            want = expected_q.pop_front();
            if (got.kind !== want.kind)
                report($sformatf("event_kind %0d, want %0d", got.kind, want.kind));
            if (got.data !== want.data)
                report($sformatf("frame_byte %02h, want %02h", got.data, want.data));
            if (got.last !== want.last)
                report($sformatf("frame_last %0b, want %0b", got.last, want.last));
            if (got.flen !== want.flen)
                report($sformatf("frame_length %0d, want %0d", got.flen, want.flen));
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    mlfd_rx_if rx_ch ();
    mlfd_ev_if evt_ch ();

    frame_scoreboard sb;
    int unsigned     idle_pct;
    int unsigned     stall_pct;
    int unsigned     bytes_sent;
    int unsigned     cycle_cnt;

    magic_length_frame_deframer_unit #(
        .MAX_FRAME    (MAX_FRAME),
        .HEADER_BYTES (HEADER_BYTES),
        .CRC_BYTES    (CRC_BYTES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_evt   (evt_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("FAIL magic_length_frame_deframer_unit");
            $finish;
        end
    end

    // Check every result transfer, then pick the next ready level.
    always @(posedge i_clk) begin
        if (i_rst_n && evt_ch.valid && evt_ch.ready)
            sb.check('{t_event_kind'(evt_ch.event_kind), evt_ch.frame_byte,
                       evt_ch.frame_last, evt_ch.frame_length});
        evt_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(99) < idle_pct) begin
            rx_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge i_clk); while (!rx_ch.ready);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic send_header(input logic [7:0] m0, input logic [7:0] m1,
                               input logic [7:0] ver, input logic [15:0] len);
        send_byte(m0);
        send_byte(m1);
        send_byte(ver);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
    endtask

    task automatic send_valid_frame(input int unsigned plen);
        send_header(sb.magic_a, sb.magic_b, sb.version_req, 16'(plen));
        repeat (plen + CRC_BYTES) send_byte(8'($urandom));
    endtask

    task automatic send_sequence();
        int unsigned pick;
        int unsigned plen;
        pick = $urandom_range(99);
        if (pick < 60) begin
            plen = ($urandom_range(7) == 0) ? $urandom_range(MAX_PAYLOAD, 9)
                                            : $urandom_range(8, 0);
            send_valid_frame(plen);
        end else if (pick < 70) begin
            send_header(sb.magic_a, sb.magic_b,
                        sb.version_req ^ 8'($urandom_range(255, 1)), 16'($urandom));
        end else if (pick < 80) begin
            send_header(sb.magic_a, sb.magic_b, sb.version_req,
                        16'($urandom_range(65535, MAX_PAYLOAD + 1)));
        end else if (pick < 90) begin
            // noise, sometimes a lone first magic byte ahead of it
            if ($urandom_range(1) == 1) send_byte(sb.magic_a);
            repeat ($urandom_range(3, 1)) send_byte(8'($urandom));
        end else begin
            // cut short: later bytes complete it
            plen = $urandom_range(8, 2);
            send_header(sb.magic_a, sb.magic_b, sb.version_req, 16'(plen));
            repeat ($urandom_range(plen, 0)) send_byte(8'($urandom));
        end
    endtask

    // Hold input until every result is out and the rescan has surely ended.
    task automatic settle_link();
        rx_ch.valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_access(input t_reg_idx idx, input logic write_en,
                              input logic [7:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write_en;
        paddr   <= CFG_ADDR_W'(int'(idx) * 4);
        pwdata  <= CFG_DATA_W'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (write_en)
            sb.set_reg(idx, v);
        else if (prdata[7:0] !== v)
            sb.report($sformatf("register %0d reads %02h, want %02h", idx, prdata[7:0], v));
        psel    <= 1'b0;
        penable <= 1'b0;
        // bus idle between transfers
        @(posedge i_clk);
    endtask

    task automatic load_config(input logic [7:0] m0, input logic [7:0] m1,
                               input logic [7:0] ver);
        settle_link();
        reg_access(REG_MAGIC_FIRST, 1'b1, m0);
        reg_access(REG_MAGIC_SECOND, 1'b1, m1);
        reg_access(REG_VERSION_EXPECTED, 1'b1, ver);
        reg_access(REG_MAGIC_FIRST, 1'b0, m0);
        reg_access(REG_MAGIC_SECOND, 1'b0, m1);
        reg_access(REG_VERSION_EXPECTED, 1'b0, ver);
    endtask

    task automatic run_random(input bit with_full_frame);
        int unsigned start;
        start = bytes_sent;
        if (with_full_frame) send_valid_frame(MAX_PAYLOAD);
        while (bytes_sent - start < PHASE_BYTES) send_sequence();
    endtask

    initial begin
        sb            = new();
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = 8'h00;
        evt_ch.ready  = 1'b0;
        idle_pct      = 0;
        stall_pct     = 0;
        bytes_sent    = 0;
        cycle_cnt     = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values
        reg_access(REG_MAGIC_FIRST, 1'b0, 8'h00);
        reg_access(REG_MAGIC_SECOND, 1'b0, 8'h00);
        reg_access(REG_VERSION_EXPECTED, 1'b0, VERSION_RESET);

        // directed part under reset configuration
        send_byte(8'hFF);
        send_header(sb.magic_a, sb.magic_b, sb.version_req, 16'd0);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_header(sb.magic_a, sb.magic_b, 8'h02, 16'hFFFF);
        send_header(sb.magic_a, sb.magic_b, sb.version_req, 16'(MAX_PAYLOAD + 1));
        send_header(sb.magic_a, sb.magic_b, sb.version_req, 16'hFFFF);

        load_config(8'hFF, 8'hFF, 8'hFF);
        run_random(1'b1);

        load_config(8'h00, 8'h00, 8'h00);
        idle_pct = 88;
        run_random(1'b0);

        load_config(8'($urandom), 8'($urandom), 8'($urandom));
        idle_pct  = 0;
        stall_pct = 88;
        run_random(1'b0);

        load_config(8'($urandom), 8'($urandom), 8'($urandom));
        idle_pct  = 21;
        stall_pct = 21;
        run_random(1'b0);

        settle_link();
        if (sb.errors == 0)
            $display("PASS magic_length_frame_deframer_unit");
        else
            $display("FAIL magic_length_frame_deframer_unit");
        $finish;
    end

endmodule
